### design/ttci_pkg.sv
package ttci_pkg;

    localparam int ROWS_DEF = 10;
    localparam int COLS_DEF = 10;
    localparam int POS_W    = 6;

    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_CMD,
        PH_COLUMN
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             clr;
        logic             wr;
        logic             ins;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [7:0]       ch;
        logic             rd_load;
        logic             rd_shift;
        logic [3:0]       rd_row;
        logic [3:0]       rd_col;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cursor_row;
        logic [3:0] cursor_col;
        logic       insert_mode;
    } result_t;

endpackage

### design/ttci_if.sv
interface ttci_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [3:0] read_row;
    logic [3:0] read_col;

    modport source (output valid, operation, char_code, read_row, read_col, input ready);
    modport sink (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface ttci_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [3:0] cursor_row;
    logic [3:0] cursor_col;
    logic       insert_mode;

    modport source (output valid, cell_char, cursor_row, cursor_col, insert_mode, input ready);
    modport sink (input valid, cell_char, cursor_row, cursor_col, insert_mode, output ready);
endinterface

### design/ttci_cell.sv
module ttci_cell
    import ttci_pkg::*;
#(
    parameter int CELL_ROW = 0,
    parameter int CELL_COL = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [7:0] left_data,
    input  logic [7:0] left_rd_data,
    input  logic       left_rd_valid,
    output logic [7:0] data,
    output logic [7:0] rd_data,
    output logic       rd_valid
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic [7:0] rd_data_reg;
    logic [7:0] rd_data_next;
    logic       rd_valid_reg;
    logic       rd_valid_next;
    logic       on_row;
    logic       hit;
    logic       right_of;
    logic       rd_hit;

    assign on_row   = (cmd.row == POS_W'(CELL_ROW));
    assign hit      = on_row && (cmd.col == POS_W'(CELL_COL));
    assign right_of = on_row && (POS_W'(CELL_COL) > cmd.col);
    assign rd_hit   = (int'(cmd.rd_row) == CELL_ROW) && (int'(cmd.rd_col) == CELL_COL);

    always_comb
    begin
        data_next     = data_reg;
        rd_data_next  = rd_data_reg;
        rd_valid_next = rd_valid_reg;
        if (cmd.clr)
        begin
            data_next = CH_SPACE;
        end
        else if (cmd.wr)
        begin
            if (hit)
            begin
                data_next = cmd.ch;
            end
            else if (cmd.ins && right_of)
            begin
                data_next = left_data;
            end
        end
        if (cmd.rd_load)
        begin
            rd_data_next  = data_reg;
            rd_valid_next = rd_hit;
        end
        else if (cmd.rd_shift)
        begin
            rd_data_next  = left_rd_data;
            rd_valid_next = left_rd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg     <= CH_SPACE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            data_reg     <= data_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rd_data_next;
    end

    assign data     = data_reg;
    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### design/text_terminal_control_interpreter_core.sv
// Feed, reset, unused operations and out-of-range reads give their result beat in the
// cycle after acceptance. An in-range read loads its cell value onto the chain of screen
// cells, which carries it one cell per cycle to its end, where it forms the result beat.
// One beat is in work at a time; a new beat is taken in the cycle its result is taken.
// Reset fills the screen with spaces, homes the cursor and selects overwrite mode.
module text_terminal_control_interpreter_core
    import ttci_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    ttci_req_if.sink     req,
    ttci_rsp_if.source   rsp
);

    localparam int NCELL = ROWS * COLS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam logic [RW-1:0]    ROW_MAX   = RW'(ROWS - 1);
    localparam logic [CW-1:0]    COL_MAX   = CW'(COLS - 1);
    localparam logic [POS_W-1:0] ROW_MAX_P = POS_W'(ROWS - 1);
    localparam logic [POS_W-1:0] COL_MAX_P = POS_W'(COLS - 1);

    state_t        state_reg;
    state_t        state_next;
    phase_t        phase_reg;
    phase_t        phase_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          ins_reg;
    logic          ins_next;
    logic [3:0]    pend_reg;
    logic [3:0]    pend_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_reg;
    result_t       out_next;

    cmd_t          cmd;
    logic          take;
    logic          in_range;
    logic          is_digit;
    logic [3:0]    digit;
    logic [POS_W-1:0] col_digit;
    logic [POS_W-1:0] pend_ext;
    logic [7:0]    ch;

    logic [7:0]       cell_data [NCELL];
    logic [7:0]       cell_rd_data [NCELL];
    logic [NCELL-1:0] cell_rd_valid;

    genvar gr, gc;
    generate
        for (gr = 0; gr < ROWS; gr++)
        begin : g_row
            for (gc = 0; gc < COLS; gc++)
            begin : g_col
                localparam int IDX = gr * COLS + gc;
                logic [7:0] left_data;
                logic [7:0] left_rd_data;
                logic       left_rd_valid;
                if (IDX == 0)
                begin : g_first
                    assign left_data     = CH_SPACE;
                    assign left_rd_data  = 8'h00;
                    assign left_rd_valid = 1'b0;
                end
                else
                begin : g_link
                    assign left_data     = cell_data[IDX-1];
                    assign left_rd_data  = cell_rd_data[IDX-1];
                    assign left_rd_valid = cell_rd_valid[IDX-1];
                end
                ttci_cell #(
                    .CELL_ROW (gr),
                    .CELL_COL (gc)
                ) u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .cmd           (cmd),
                    .left_data     (left_data),
                    .left_rd_data  (left_rd_data),
                    .left_rd_valid (left_rd_valid),
                    .data          (cell_data[IDX]),
                    .rd_data       (cell_rd_data[IDX]),
                    .rd_valid      (cell_rd_valid[IDX])
                );
            end
        end
    endgenerate

    assign ch        = req.char_code;
    assign is_digit  = ch inside {[CH_ZERO:CH_NINE]};
    assign digit     = 4'(ch - CH_ZERO);
    assign col_digit = is_digit ? POS_W'(digit) : '0;
    assign pend_ext  = POS_W'(pend_reg);
    assign in_range  = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLS);
    assign take      = (state_reg == S_IDLE) || ((state_reg == S_OUT) && rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ins_next       = ins_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        cmd          = '0;
        cmd.row      = POS_W'(row_reg);
        cmd.col      = POS_W'(col_reg);
        cmd.ch       = ch;
        cmd.ins      = ins_reg;
        cmd.rd_row   = req.read_row;
        cmd.rd_col   = req.read_col;

        if ((state_reg == S_OUT) && rsp.ready)
        begin
            out_valid_next = 1'b0;
            state_next     = S_IDLE;
        end

        if (state_reg == S_READ)
        begin
            cmd.rd_shift = !cell_rd_valid[NCELL-1];
            if (cell_rd_valid[NCELL-1])
            begin
                out_next.cell_char = cell_rd_data[NCELL-1];
                out_valid_next     = 1'b1;
                state_next         = S_OUT;
            end
        end

        if (take && req.valid)
        begin
            out_valid_next     = 1'b1;
            state_next         = S_OUT;
            out_next.cell_char = 8'h00;
            case (req.operation)
                OP_FEED:
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            phase_next = PH_TEXT;
                            case (ch)
                                CH_B: col_next = '0;
                                CH_C: cmd.clr = 1'b1;
                                CH_D:
                                begin
                                    if (row_reg < ROW_MAX)
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                CH_U:
                                begin
                                    if (row_reg != '0)
                                    begin
                                        row_next = row_reg - 1'b1;
                                    end
                                end
                                CH_L:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 1'b1;
                                    end
                                end
                                CH_R:
                                begin
                                    if (col_reg < COL_MAX)
                                    begin
                                        col_next = col_reg + 1'b1;
                                    end
                                end
                                CH_E:
                                begin
                                    cmd.wr  = 1'b1;
                                    cmd.ins = 1'b0;
                                    cmd.ch  = CH_SPACE;
                                end
                                CH_H:
                                begin
                                    row_next = '0;
                                    col_next = '0;
                                end
                                CH_I: ins_next = 1'b1;
                                CH_O: ins_next = 1'b0;
                                CH_CARET:
                                begin
                                    cmd.wr = 1'b1;
                                    if (col_reg < COL_MAX)
                                    begin
                                        col_next = col_reg + 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (is_digit)
                                    begin
                                        pend_next  = digit;
                                        phase_next = PH_COLUMN;
                                    end
                                end
                            endcase
                        end
                        PH_COLUMN:
                        begin
                            phase_next = PH_TEXT;
                            row_next   = (pend_ext > ROW_MAX_P) ? ROW_MAX : RW'(pend_ext);
                            col_next   = (col_digit > COL_MAX_P) ? COL_MAX : CW'(col_digit);
                        end
                        default:
                        begin
                            if (ch == CH_CARET)
                            begin
                                phase_next = PH_CMD;
                            end
                            else
                            begin
                                cmd.wr = 1'b1;
                                if (col_reg < COL_MAX)
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
                OP_READ:
                begin
                    if (in_range)
                    begin
                        cmd.rd_load    = 1'b1;
                        out_valid_next = 1'b0;
                        state_next     = S_READ;
                    end
                end
                OP_RESET:
                begin
                    cmd.clr    = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    ins_next   = 1'b0;
                    phase_next = PH_TEXT;
                    pend_next  = '0;
                end
                default:
                begin
                end
            endcase
        end

        out_next.cursor_row  = 4'(row_next);
        out_next.cursor_col  = 4'(col_next);
        out_next.insert_mode = ins_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TEXT;
            row_reg       <= '0;
            col_reg       <= '0;
            ins_reg       <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ins_reg       <= ins_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign req.ready       = take;
    assign rsp.valid       = out_valid_reg;
    assign rsp.cell_char   = out_reg.cell_char;
    assign rsp.cursor_row  = out_reg.cursor_row;
    assign rsp.cursor_col  = out_reg.cursor_col;
    assign rsp.insert_mode = out_reg.insert_mode;

`ifndef NO_ASSERTIONS
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= ROW_MAX) && (col_reg <= COL_MAX))
        else $error("cursor left the screen");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $onehot0(cell_rd_valid))
        else $error("more than one cell value travels on the read chain");

    a_read_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_load |=> $onehot(cell_rd_valid))
        else $error("in-range read found no cell");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (!out_valid_reg || rsp.ready))
        else $error("beat accepted over a pending result");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> (cell_data[0] == CH_SPACE) && (cell_data[NCELL-1] == CH_SPACE))
        else $error("screen clear did not reach the cells");
`endif

endmodule

### sim/text_terminal_control_interpreter_core_tb.sv
`timescale 1ns / 100ps

module text_terminal_control_interpreter_core_tb
    import ttci_pkg::*;
;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         TARGET_RANDOM = 400;

    class terminal_scoreboard;
        logic [7:0] screen_cells [ROWS_DEF][COLS_DEF];
        logic [3:0] cur_row;
        logic [3:0] cur_col;
        logic       ins_mode;
        phase_t     parse_state;
        logic [3:0] held_row;
        result_t    pending_status [$];
        int         mismatches;

        function new();
            mismatches = 0;
            clear_session();
        endfunction

        function void clear_cells();
            foreach (screen_cells[r, c])
                screen_cells[r][c] = CH_SPACE;
        endfunction

        function void clear_session();
            clear_cells();
            cur_row     = '0;
            cur_col     = '0;
            ins_mode    = 1'b0;
            parse_state = PH_TEXT;
            held_row    = '0;
        endfunction

        function void put_char(logic [7:0] ch);
            if (ins_mode)
                for (int j = COLS_DEF - 1; j > cur_col; j--)
                    screen_cells[cur_row][j] = screen_cells[cur_row][j-1];
            screen_cells[cur_row][cur_col] = ch;
            if (cur_col < COLS_DEF - 1)
                cur_col = cur_col + 1'b1;
        endfunction

        function void feed_byte(logic [7:0] ch);
            logic       is_digit;
            logic [7:0] digit;
            is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            digit    = ch - CH_ZERO;
            case (parse_state)
                PH_CMD:
                begin
                    parse_state = PH_TEXT;
                    case (ch)
                        CH_B:     cur_col = '0;
                        CH_C:     clear_cells();
                        CH_D:     if (cur_row < ROWS_DEF - 1) cur_row = cur_row + 1'b1;
                        CH_U:     if (cur_row > 0) cur_row = cur_row - 1'b1;
                        CH_L:     if (cur_col > 0) cur_col = cur_col - 1'b1;
                        CH_R:     if (cur_col < COLS_DEF - 1) cur_col = cur_col + 1'b1;
                        CH_E:     screen_cells[cur_row][cur_col] = CH_SPACE;
                        CH_H:
                        begin
                            cur_row = '0;
                            cur_col = '0;
                        end
                        CH_I:     ins_mode = 1'b1;
                        CH_O:     ins_mode = 1'b0;
                        CH_CARET: put_char(ch);
                        default:
                        begin
                            if (is_digit)
                            begin
                                held_row    = digit[3:0];
                                parse_state = PH_COLUMN;
                            end
                        end
                    endcase
                end
                PH_COLUMN:
                begin
                    if (!is_digit)
                        digit = '0;
                    cur_row     = (held_row > ROWS_DEF - 1) ? 4'(ROWS_DEF - 1) : held_row;
                    cur_col     = (digit > COLS_DEF - 1) ? 4'(COLS_DEF - 1) : digit[3:0];
                    parse_state = PH_TEXT;
                end
                default:
                begin
                    if (ch == CH_CARET)
                        parse_state = PH_CMD;
                    else
                        put_char(ch);
                end
            endcase
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] ch, logic [3:0] rr,
                                   logic [3:0] rc);
            result_t status;
            status.cell_char = '0;
            case (op)
                OP_FEED:  feed_byte(ch);
                OP_READ:
                begin
                    if (rr < ROWS_DEF && rc < COLS_DEF)
                        status.cell_char = screen_cells[rr][rc];
                end
                OP_RESET: clear_session();
                default:  ;
            endcase
            status.cursor_row  = cur_row;
            status.cursor_col  = cur_col;
            status.insert_mode = ins_mode;
            pending_status.push_back(status);
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
                return;
            end
            want = pending_status.pop_front();
            if (got.cell_char !== want.cell_char || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col || got.insert_mode !== want.insert_mode)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h r%0d c%0d i%b, got %h r%0d c%0d i%b",
                             want.cell_char, want.cursor_row, want.cursor_col, want.insert_mode,
                             got.cell_char, got.cursor_row, got.cursor_col, got.insert_mode);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    int   random_beats;

    terminal_scoreboard sb;

    ttci_req_if req_bus ();
    ttci_rsp_if rsp_bus ();

    text_terminal_control_interpreter_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            result_t got;
            got.cell_char   = rsp_bus.cell_char;
            got.cursor_row  = rsp_bus.cursor_row;
            got.cursor_col  = rsp_bus.cursor_col;
            got.insert_mode = rsp_bus.insert_mode;
            sb.check_status(got);
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch,
                             input logic [3:0] rr, input logic [3:0] rc);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.char_code <= ch;
        req_bus.read_row  <= rr;
        req_bus.read_col  <= rc;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(op, ch, rr, rc);
    endtask

    task automatic feed_char(input logic [7:0] ch);
        send_beat(OP_FEED, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endtask

    task automatic read_cell(input logic [3:0] rr, input logic [3:0] rc);
        send_beat(OP_READ, 8'($urandom_range(0, 255)), rr, rc);
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_status.size() != 0);
    endtask

    task automatic random_sequence();
        int         kind;
        logic [7:0] ch;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            if ($urandom_range(0, 9) < 6)
                ch = 8'($urandom_range(8'h41, 8'h7A));
            else
                ch = 8'($urandom_range(0, 255));
            if (ch == CH_CARET)
                ch = 8'h5F;
            feed_char(ch);
            random_beats += 1;
        end
        else if (kind < 70)
        begin
            feed_char(CH_CARET);
            case ($urandom_range(0, 13))
                0:  ch = CH_B;
                1:  ch = CH_D;
                2:  ch = CH_U;
                3:  ch = CH_L;
                4:  ch = CH_R;
                5:  ch = CH_E;
                6:  ch = CH_H;
                7:  ch = CH_I;
                8:  ch = CH_O;
                9:  ch = CH_CARET;
                10: ch = ($urandom_range(0, 1) != 0) ? CH_C : CH_D;
                11: ch = 8'($urandom_range(0, 255));
                default: ch = 8'($urandom_range(CH_ZERO, CH_NINE));
            endcase
            feed_char(ch);
            random_beats += 2;
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                if ($urandom_range(0, 99) < 85)
                    feed_char(8'($urandom_range(CH_ZERO, CH_NINE)));
                else
                    feed_char(8'($urandom_range(0, 255)));
                random_beats += 1;
            end
        end
        else if (kind < 82)
        begin
            if ($urandom_range(0, 99) < 85)
                read_cell(4'($urandom_range(0, ROWS_DEF - 1)),
                          4'($urandom_range(0, COLS_DEF - 1)));
            else
                read_cell(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            random_beats += 1;
        end
        else if (kind < 86)
        begin
            send_beat(OP_RESET, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
            random_beats += 1;
        end
        else if (kind < 90)
        begin
            send_beat(OP_UNUSED, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
            random_beats += 1;
        end
        else
        begin
            feed_char(($urandom_range(0, 1) != 0) ? CH_CARET : 8'($urandom_range(0, 255)));
            random_beats += 1;
        end
    endtask

    initial
    begin
        sb                = new();
        rst_n             = 1'b0;
        cycle_count       = 0;
        random_beats      = 0;
        send_idle_pct     = 32;
        recv_stall_pct    = 75;
        req_bus.valid     = 1'b0;
        req_bus.operation = OP_FEED;
        req_bus.char_code = '0;
        req_bus.read_row  = '0;
        req_bus.read_col  = '0;
        rsp_bus.ready     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Control bytes, insert shifting, absolute moves and a literal caret.
        feed_char(8'h00);
        feed_char(8'hFF);
        feed_char(CH_CARET);
        feed_char(CH_I);
        feed_char(8'h41);
        feed_char(CH_CARET);
        feed_char(CH_NINE);
        feed_char(CH_NINE);
        feed_char(8'h5A);
        feed_char(CH_CARET);
        feed_char(CH_ZERO + 8'd5);
        feed_char(8'h78);
        feed_char(CH_CARET);
        feed_char(CH_CARET);
        feed_char(CH_CARET);
        feed_char(8'h71);
        read_cell(4'd0, 4'd0);
        read_cell(4'd9, 4'd9);
        read_cell(4'd5, 4'd0);
        read_cell(4'd15, 4'd15);
        read_cell(4'd10, 4'd3);
        send_beat(OP_UNUSED, 8'hA5, 4'd2, 4'd2);
        feed_char(CH_CARET);
        send_beat(OP_RESET, 8'h00, 4'd0, 4'd0);
        read_cell(4'd9, 4'd9);

        while (random_beats < TARGET_RANDOM / 3)
            random_sequence();
        drain_results();
        send_idle_pct  = 75;
        recv_stall_pct = 32;
        while (random_beats < 2 * TARGET_RANDOM / 3)
            random_sequence();
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (random_beats < TARGET_RANDOM)
            random_sequence();
        drain_results();

        repeat (ROWS_DEF * COLS_DEF + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_status.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
